// ===== hw/rtl/osts_pkg.sv =====
// Shared constants and types for the order-statistic counting tree.
`timescale 1ns / 1ps
package osts_pkg;
    localparam int KEY_W   = 10;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic valid;
        logic sel;
    } t_walk;
endpackage

// ===== hw/rtl/osts_cell.sv =====
// One tree level: its left counts, the step that updates one of them and the turn taken.
`timescale 1ns / 1ps
module osts_cell #(
    parameter int LEVELS = 10,
    parameter int LVL    = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  osts_pkg::t_walk               i_walk,
    input  logic [LEVELS-1:0]             i_node,
    input  logic [osts_pkg::KEY_W-1:0]    i_rank,
    input  logic                          i_key_bit,
    input  logic                          i_clr,
    input  logic [LEVELS-2:0]             i_clr_addr,
    output osts_pkg::t_walk               o_walk,
    output logic [LEVELS-1:0]             o_node,
    output logic [osts_pkg::KEY_W-1:0]    o_rank
);
    import osts_pkg::*;

    localparam int IW    = (LVL == 0) ? 1 : LVL;
    localparam int DEPTH = 1 << IW;

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_cnt;
    t_walk              r_walk;
    logic [LEVELS-1:0]  r_node;
    logic [KEY_W-1:0]   r_rank;
    logic               go_right;
    logic [COUNT_W-1:0] n_cnt;

    always_comb begin
        if (r_walk.sel) begin
            go_right = (r_cnt <= COUNT_W'(r_rank));
            n_cnt    = r_cnt - COUNT_W'(1);
        end else begin
            go_right = i_key_bit;
            n_cnt    = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_clr_addr[IW-1:0]] <= '0;
        end else if (r_walk.valid && !go_right) begin
            r_mem[r_node[IW-1:0]] <= n_cnt;
        end
        if (i_walk.valid) begin
            r_cnt <= r_mem[i_node[IW-1:0]];
        end
        r_node <= i_node;
        r_rank <= i_rank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else begin
            r_walk <= i_walk;
        end
    end

    assign o_walk = r_walk;
    assign o_node = {r_node[LEVELS-2:0], go_right};
    assign o_rank = (r_walk.sel && go_right) ? r_rank - r_cnt[KEY_W-1:0] : r_rank;
endmodule

// ===== hw/rtl/order_statistic_tree_select.sv =====
// Top level of the order-statistic counting tree: command control, clearing sweep, level chain.
// An accepted insert or select walks the chain of level cells, registered at each tree level; for
// a select the selected key is on o_selected_key with o_strobe, registered after the last level.
// busy stays high until the walk leaves the last level, so the next item is taken only then. A
// clear sweeps LEAVES/2 addresses, one count per level each cycle; after reset the same clearing
// sweep runs with busy high. The receiver cannot stall; every result is shown for one cycle only.
`timescale 1ns / 1ps
module order_statistic_tree_select #(
    parameter int LEAVES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [osts_pkg::CMD_W-1:0]    i_cmd,
    input  logic [osts_pkg::KEY_W-1:0]    i_key,
    input  logic [osts_pkg::KEY_W-1:0]    i_rank,
    output logic                          o_strobe,
    output logic [osts_pkg::KEY_W-1:0]    o_selected_key
);
    import osts_pkg::*;

    localparam int LEVELS = $clog2(LEAVES);
    localparam int KX_W   = (LEVELS > KEY_W) ? LEVELS : KEY_W;

    t_walk              walk [LEVELS+1];
    logic [LEVELS-1:0]  node [LEVELS+1];
    logic [KEY_W-1:0]   rank [LEVELS+1];

    logic               r_busy;
    logic               r_sweep;
    logic [LEVELS-2:0]  r_sweep_cnt;
    logic [LEVELS-1:0]  r_key;
    logic               r_strobe;
    logic [KEY_W-1:0]   r_sel_key;
    logic               accept;
    logic [KX_W-1:0]    key_ext;

    assign busy    = r_busy | r_sweep;
    assign accept  = start && !busy;
    assign key_ext = KX_W'(i_key);

    assign walk[0].valid = accept && (i_cmd inside {CMD_INSERT, CMD_SELECT});
    assign walk[0].sel   = (i_cmd == CMD_SELECT);
    assign node[0]       = '0;
    assign rank[0]       = i_rank;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        osts_cell #(
            .LEVELS (LEVELS),
            .LVL    (l)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_walk     (walk[l]),
            .i_node     (node[l]),
            .i_rank     (rank[l]),
            .i_key_bit  (r_key[LEVELS-1-l]),
            .i_clr      (r_sweep),
            .i_clr_addr (r_sweep_cnt),
            .o_walk     (walk[l+1]),
            .o_node     (node[l+1]),
            .o_rank     (rank[l+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= key_ext[LEVELS-1:0];
        end
        r_sel_key <= KEY_W'(node[LEVELS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sweep     <= 1'b1;
            r_sweep_cnt <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= walk[LEVELS].valid && walk[LEVELS].sel;
            if (walk[0].valid) begin
                r_busy <= 1'b1;
            end else if (walk[LEVELS].valid) begin
                r_busy <= 1'b0;
            end
            if (r_sweep) begin
                r_sweep_cnt <= r_sweep_cnt + (LEVELS-1)'(1);
                if (&r_sweep_cnt) begin
                    r_sweep <= 1'b0;
                end
            end else if (accept && i_cmd == CMD_CLEAR) begin
                r_sweep     <= 1'b1;
                r_sweep_cnt <= '0;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_selected_key = r_sel_key;

    a_no_walk_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !walk[0].valid && !walk[LEVELS].valid)
        else $error("walk active during clearing sweep");
    a_busy_on_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk[0].valid |=> busy)
        else $error("busy not raised after an accepted item");
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");
endmodule
